// File: src/lst_pkg.sv
// shared widths, constants and types of the lane speed tracker
package lst_pkg;

    localparam int VEL_W       = 15;
    localparam int POS_W       = 21;
    localparam int LAT_W       = 13;
    localparam int SPD_W       = 15;
    localparam int LANE_BITS   = 2;
    localparam int NUM_LANES   = 3;
    localparam int BACKLOG_W   = 6;
    localparam int EGO_LANE_W  = 2;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_IDX_W   = 2;

    // lane width of 4 m in 1/256 units is 2**10
    localparam int LANE_SHIFT  = 10;

    // path points per second of prediction, 0.02 s each
    localparam int PATH_POINTS = 50;

    // bit-serial root: 30-bit radicand, one root bit per cycle
    localparam int RAD_W       = 2 * SPD_W;
    localparam int ROOT_ITER   = SPD_W;
    localparam int ITER_CNT_W  = $clog2(ROOT_ITER);
    localparam int REM_W       = SPD_W + 2;

    // division by PATH_POINTS as multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PATH_POINTS) - 64'd1) / 64'(PATH_POINTS));

    // shared multiplier
    localparam int MUL_A_W     = POS_W;
    localparam int MUL_B_W     = RECIP_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    // signed distance and the 30 m window
    localparam int DIST_W      = POS_W + 2;
    localparam int NEAR_RANGE  = 30 * 256;

    localparam logic [SPD_W-1:0] SPEED_LIMIT_RST = SPD_W'(12672);
    localparam logic [EGO_LANE_W-1:0] EGO_LANE_RST = EGO_LANE_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_EGO_LANE    = 2'd1,
        CFG_EGO_POS     = 2'd2,
        CFG_BACKLOG     = 2'd3
    } t_cfg_idx;

    typedef logic [SPD_W-1:0] t_speed;

    // command from the sequencer to the lane state
    typedef struct packed {
        logic                 frame_start;
        logic                 update;
        logic [LANE_BITS-1:0] lane;
        t_speed               speed;
        logic                 frame_end;
    } t_lane_cmd;

endpackage

// File: src/lst_isqrt.sv
// bit-serial integer square root, one root bit per cycle
module lst_isqrt
    import lst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_done,
    output t_speed           o_root
);

    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    t_speed                r_root;
    logic [ITER_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = (REM_W + 2)'({r_root, 2'b01});
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == ITER_CNT_W'(ROOT_ITER - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITER_CNT_W'(ROOT_ITER - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root <= {r_root[SPD_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: src/lst_lanes.sv
// per-lane minimum speed, too-close flag and frame tracking
module lst_lanes
    import lst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_cmd i_cmd,
    input  t_speed    i_speed_limit,
    output logic      o_frame_open,
    output t_speed    o_min_speed [NUM_LANES],
    output logic      o_close     [NUM_LANES]
);

    t_speed r_min  [NUM_LANES];
    logic   r_flag [NUM_LANES];
    logic   r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_min[k]  <= SPEED_LIMIT_RST;
                r_flag[k] <= 1'b0;
            end
        end else begin
            if (i_cmd.frame_start) begin
                r_open <= 1'b1;
                for (int k = 0; k < NUM_LANES; k++) begin
                    r_min[k]  <= i_speed_limit;
                    r_flag[k] <= 1'b0;
                end
            end else if (i_cmd.update) begin
                for (int k = 0; k < NUM_LANES; k++) begin
                    if (i_cmd.lane == LANE_BITS'(k)) begin
                        r_flag[k] <= 1'b1;
                        if (i_cmd.speed < r_min[k]) begin
                            r_min[k] <= i_cmd.speed;
                        end
                    end
                end
            end
            if (i_cmd.frame_end) begin
                r_open <= 1'b0;
            end
        end
    end

    assign o_frame_open = r_open;
    assign o_min_speed  = r_min;
    assign o_close      = r_flag;

endmodule

// File: src/lane_speed_tracker_core.sv
// lane speed tracker top level: sequencer, shared multiplier, config and output register
//
// one tracked car per request; the next car is accepted once the previous one has been
// folded into its lane and, for the last car of a frame, its result has entered the
// result register (later while a finished result is still stalled). the sequencer steps
// through vx^2 and vy^2 on the single shared multiplier, the start of the root, the
// bit-serial square root (15 root bits, then a completion flag), backlog*speed and the
// multiply by the reciprocal of the path point count, the lane update, the emit for
// the last car of a frame, and the idle state in which the next car is taken. o_stall is
// high from acceptance until the car is folded into its lane, for a frame's last car
// until its result is in the result register. the result of a frame (min speed and
// too-close flag for each lane) is delivered once, on the car flagged last; it sits in
// an output register so the next frame's first car can be taken while the result is
// still stalled. config writes are always accepted and should only be issued while no
// car is in flight; speed_limit is sampled at the first car of every frame.
module lane_speed_tracker_core
    import lst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // car request channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [VEL_W-1:0]  i_vel_x,
    input  logic signed [VEL_W-1:0]  i_vel_y,
    input  logic [POS_W-1:0]         i_track_pos,
    input  logic signed [LAT_W-1:0]  i_lateral_pos,
    input  logic                     i_last_car,

    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [SPD_W-1:0]         o_left_lane_speed,
    output logic [SPD_W-1:0]         o_middle_lane_speed,
    output logic [SPD_W-1:0]         o_right_lane_speed,
    output logic                     o_left_too_close,
    output logic                     o_middle_too_close,
    output logic                     o_right_too_close,

    // config write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SQX    = 9'b000000010,
        ST_SQY    = 9'b000000100,
        ST_START  = 9'b000001000,
        ST_ROOT   = 9'b000010000,
        ST_SCALE  = 9'b000100000,
        ST_RECIP  = 9'b001000000,
        ST_UPDATE = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // config registers
    t_speed                r_speed_limit;
    logic [EGO_LANE_W-1:0] r_ego_lane;
    logic [POS_W-1:0]      r_ego_pos;
    logic [BACKLOG_W-1:0]  r_backlog;

    // captured car
    logic [VEL_W-1:0]      r_abs_x;
    logic [VEL_W-1:0]      r_abs_y;
    logic [POS_W-1:0]      r_pos;
    logic [LANE_BITS-1:0]  r_lane;
    logic                  r_lane_ok;
    logic                  r_last;

    // datapath
    logic [PROD_W-1:0]     r_prod;
    logic [RAD_W-1:0]      r_rad;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;

    // result register
    logic                  r_out_valid;
    t_speed                r_out_speed [NUM_LANES];
    logic                  r_out_close [NUM_LANES];

    logic                  accept;
    logic                  emit_fire;
    logic                  root_done;
    t_speed                root;
    logic                  frame_open;
    t_speed                lane_min   [NUM_LANES];
    logic                  lane_close [NUM_LANES];
    t_lane_cmd             lane_cmd;

    logic [POS_W-1:0]        ahead;
    logic signed [DIST_W-1:0] rel_pos;
    logic                    is_ego;
    logic                    is_adj;
    logic                    in_front;
    logic                    in_window;
    logic                    counted;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && (r_state == ST_IDLE);
    assign emit_fire   = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= SPEED_LIMIT_RST;
            r_ego_lane    <= EGO_LANE_RST;
            r_ego_pos     <= '0;
            r_backlog     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[SPD_W-1:0];
                CFG_EGO_LANE:    r_ego_lane    <= i_cfg_data[EGO_LANE_W-1:0];
                CFG_EGO_POS:     r_ego_pos     <= i_cfg_data[POS_W-1:0];
                CFG_BACKLOG:     r_backlog     <= i_cfg_data[BACKLOG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // capture the car: magnitudes for squaring, lane from the offset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_abs_x   <= i_vel_x[VEL_W-1] ? VEL_W'(-i_vel_x) : VEL_W'(i_vel_x);
            r_abs_y   <= i_vel_y[VEL_W-1] ? VEL_W'(-i_vel_y) : VEL_W'(i_vel_y);
            r_pos     <= i_track_pos;
            r_lane    <= i_lateral_pos[LANE_SHIFT +: LANE_BITS];
            // negative offset or the fourth 4 m band are outside the road
            r_lane_ok <= !i_lateral_pos[LAT_W-1]
                      && (i_lateral_pos[LANE_SHIFT +: LANE_BITS] != LANE_BITS'(NUM_LANES));
            r_last    <= i_last_car;
        end
    end

    // one multiplier shared by squares, backlog scaling and the reciprocal
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQX: begin
                mul_a = MUL_A_W'(r_abs_x);
                mul_b = MUL_B_W'(r_abs_x);
            end
            ST_SQY: begin
                mul_a = MUL_A_W'(r_abs_y);
                mul_b = MUL_B_W'(r_abs_y);
            end
            ST_SCALE: begin
                mul_a = MUL_A_W'(r_backlog);
                mul_b = MUL_B_W'(root);
            end
            ST_RECIP: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = RECIP_K;
            end
            default: begin
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SQX:   r_prod <= mul_p;
            ST_SQY:   r_rad  <= r_prod[RAD_W-1:0] + mul_p[RAD_W-1:0];
            ST_SCALE: r_prod <= mul_p;
            ST_RECIP: r_prod <= mul_p;
            default: begin
            end
        endcase
    end

    lst_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_START),
        .i_radicand (r_rad),
        .o_done     (root_done),
        .o_root     (root)
    );

    // distance of the predicted car position to the own vehicle
    always_comb begin
        ahead     = r_prod[RECIP_SHIFT +: POS_W];
        rel_pos   = $signed(DIST_W'(r_pos)) + $signed(DIST_W'(ahead))
                  - $signed(DIST_W'(r_ego_pos));
        is_ego    = (r_lane == r_ego_lane);
        is_adj    = ({1'b0, r_lane} + 3'd1 == {1'b0, r_ego_lane})
                 || ({1'b0, r_lane} == {1'b0, r_ego_lane} + 3'd1);
        in_front  = (rel_pos > $signed(DIST_W'(0)))
                 && (rel_pos < $signed(DIST_W'(NEAR_RANGE)));
        in_window = (rel_pos > -$signed(DIST_W'(NEAR_RANGE)))
                 && (rel_pos < $signed(DIST_W'(NEAR_RANGE)));
        counted   = r_lane_ok && (is_ego ? in_front : (is_adj && in_window));
    end

    always_comb begin
        lane_cmd.frame_start = accept && !frame_open;
        lane_cmd.update      = (r_state == ST_UPDATE) && counted;
        lane_cmd.lane        = r_lane;
        lane_cmd.speed       = root;
        lane_cmd.frame_end   = emit_fire;
    end

    lst_lanes u_lanes (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (lane_cmd),
        .i_speed_limit (r_speed_limit),
        .o_frame_open  (frame_open),
        .o_min_speed   (lane_min),
        .o_close       (lane_close)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_SQX;
            ST_SQX:    n_state = ST_SQY;
            ST_SQY:    n_state = ST_START;
            ST_START:  n_state = ST_ROOT;
            ST_ROOT:   if (root_done) n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_RECIP;
            ST_RECIP:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (emit_fire) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result register, refilled only once the previous result has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_speed <= lane_min;
            r_out_close <= lane_close;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_left_lane_speed   = r_out_speed[0];
    assign o_middle_lane_speed = r_out_speed[1];
    assign o_right_lane_speed  = r_out_speed[2];
    assign o_left_too_close    = r_out_close[0];
    assign o_middle_too_close  = r_out_close[1];
    assign o_right_too_close   = r_out_close[2];

    // root unit only finishes while the sequencer waits for it
    a_root_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> (r_state == ST_ROOT))
        else $error("root finished outside root wait");

    // a new result only appears after the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_EMIT))
        else $error("result appeared without emit");

    // lane state never changes while a car is being squared or rooted
    a_no_update_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_cmd.update |-> (r_state == ST_UPDATE) && r_lane_ok)
        else $error("lane update outside update step");

    // the last car of a frame always closes the frame through emit
    a_last_goes_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) && r_last |=> (r_state == ST_EMIT))
        else $error("last car did not reach emit");

endmodule
